>>> hw/rtl/vpia_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and arctangent table of the vector pair incline angle block.
package vpia_pkg;

    localparam int COMPONENT_WIDTH = 16;
    localparam int ANGLE_FRAC_DEF  = 8;
    localparam int NORM_W          = 17;
    localparam int NORM_LIMIT      = 32768;
    localparam int TABLE_FRAC      = 24;
    localparam int CORDIC_STEPS    = 28;
    localparam int SQRT_STEPS      = 32;
    localparam int ANGLE_W         = 15;
    localparam int RIGHT_ANGLE     = 90;
    localparam int MID_DEPTH       = 4;
    localparam int OUT_DEPTH       = 2;

    typedef struct packed {
        logic signed [COMPONENT_WIDTH-1:0] ax;
        logic signed [COMPONENT_WIDTH-1:0] ay;
        logic signed [COMPONENT_WIDTH-1:0] az;
        logic signed [COMPONENT_WIDTH-1:0] bx;
        logic signed [COMPONENT_WIDTH-1:0] by;
        logic signed [COMPONENT_WIDTH-1:0] bz;
    } t_vpia_in;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle_deg;
        logic               degenerate;
    } t_vpia_out;

    typedef struct packed {
        logic [63:0] cross2;
        logic [31:0] dot_mag;
        logic        degenerate;
    } t_vpia_mid;

    // atan(2^-i) in degrees, Q8.24
    function automatic logic [31:0] atan_q24(input int idx);
        logic [31:0] v;
        case (idx)
            0:       v = 32'd754974720;
            1:       v = 32'd445687602;
            2:       v = 32'd235489088;
            3:       v = 32'd119537938;
            4:       v = 32'd60000934;
            5:       v = 32'd30029717;
            6:       v = 32'd15018523;
            7:       v = 32'd7509720;
            8:       v = 32'd3754917;
            9:       v = 32'd1877466;
            10:      v = 32'd938734;
            11:      v = 32'd469367;
            12:      v = 32'd234684;
            13:      v = 32'd117342;
            14:      v = 32'd58671;
            15:      v = 32'd29335;
            16:      v = 32'd14668;
            17:      v = 32'd7334;
            18:      v = 32'd3667;
            19:      v = 32'd1833;
            20:      v = 32'd917;
            21:      v = 32'd458;
            22:      v = 32'd229;
            23:      v = 32'd115;
            24:      v = 32'd57;
            25:      v = 32'd29;
            26:      v = 32'd14;
            27:      v = 32'd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> hw/rtl/vector_pair_incline_angle.sv
`timescale 1ns / 1ps
// Top level of the vector pair incline angle block: front, mid queue, back, result queue.
//
// Takes one pair of 3D vectors per clock and returns the angle between them, folded into
// 0 to 90 degrees (unsigned, ANGLE_FRAC_BITS fraction bits), with a flag when either vector
// is zero. A new pair is accepted every cycle while results are taken. The accepting edge
// loads the first of six front stages (scaling, products, cross terms, squares, sum).
// The sum stage writes the mid queue. Then come 64 back stages: an input register, a
// 32-stage integer square root, two leading-zero scaling stages, 28 CORDIC stages and a
// rounding stage, which writes the result queue. The result queue holds two words; when it
// fills, the back stalls, then the mid queue fills and full rises.
module vector_pair_incline_angle import vpia_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_vpia_in  i_pair,
    input  logic      pop,
    output logic      empty,
    output t_vpia_out o_angle
);
    logic      w_mid_push;
    logic      w_mid_full;
    logic      w_mid_pop;
    logic      w_mid_empty;
    t_vpia_mid w_mid_in;
    t_vpia_mid w_mid_out;
    logic      w_out_push;
    logic      w_out_full;
    t_vpia_out w_res;

    vpia_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_pair     (i_pair),
        .o_push     (w_mid_push),
        .i_mid_full (w_mid_full),
        .o_mid      (w_mid_in)
    );

    vpia_fifo #(
        .WIDTH ($bits(t_vpia_mid)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_mid_push),
        .i_data  (w_mid_in),
        .o_full  (w_mid_full),
        .i_pop   (w_mid_pop),
        .o_data  (w_mid_out),
        .o_empty (w_mid_empty)
    );

    vpia_back #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid       (w_mid_out),
        .i_mid_empty (w_mid_empty),
        .o_mid_pop   (w_mid_pop),
        .o_push      (w_out_push),
        .i_out_full  (w_out_full),
        .o_res       (w_res)
    );

    vpia_fifo #(
        .WIDTH ($bits(t_vpia_out)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_data  (w_res),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_data  (o_angle),
        .o_empty (empty)
    );

    a_mid_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mid_push |-> !w_mid_full)
        else $error("mid queue written while full");

    a_mid_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mid_pop |-> !w_mid_empty)
        else $error("mid queue read while empty");

    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_angle.degenerate) |-> (o_angle.angle_deg == '0))
        else $error("degenerate word with nonzero angle");

endmodule

>>> hw/rtl/vpia_fifo.sv
`timescale 1ns / 1ps
// Small register queue used between the front, the back and the result port.
module vpia_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;
    logic             wr;
    logic             rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/vpia_front.sv
`timescale 1ns / 1ps
// Front pipeline: scale vectors, form dot product magnitude and squared cross product.
module vpia_front import vpia_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    output logic      o_full,
    input  t_vpia_in  i_pair,
    output logic      o_push,
    input  logic      i_mid_full,
    output t_vpia_mid o_mid
);
    localparam int NST = 6;
    localparam int MW  = COMPONENT_WIDTH;
    localparam int EW  = MW + NORM_W;
    localparam int SHW = $clog2(MW + 1);
    localparam int PW  = 2 * NORM_W;

    logic [NST-1:0]           r_v;
    logic                     adv;
    t_vpia_in                 r_in;
    logic [3*NORM_W-1:0]      w_na;
    logic [3*NORM_W-1:0]      w_nb;
    logic signed [NORM_W-1:0] r_a [3];
    logic signed [NORM_W-1:0] r_b [3];
    logic                     r_dg1;
    logic signed [PW-1:0]     w_p [9];
    logic signed [31:0]       r_p [9];
    logic                     r_dg2;
    logic signed [32:0]       w_dot;
    logic signed [32:0]       w_cr [3];
    logic [31:0]              r_cm [3];
    logic [31:0]              r_dm;
    logic                     r_dg3;
    logic [63:0]              r_sq [3];
    logic [31:0]              r_dm4;
    logic                     r_dg4;
    t_vpia_mid                r_out;

    // Shift all three magnitudes right until the largest is at most 2^15.
    function automatic logic [3*NORM_W-1:0] norm_vec(input logic [MW-1:0] c0,
                                                     input logic [MW-1:0] c1,
                                                     input logic [MW-1:0] c2);
        logic [MW-1:0]     c [3];
        logic [MW-1:0]     m [3];
        logic              ng [3];
        logic [MW-1:0]     mx;
        logic [EW-1:0]     mxe;
        logic [SHW-1:0]    sh;
        logic [MW-1:0]     t;
        logic [NORM_W-1:0] tz;
        logic [3*NORM_W-1:0] res;
        c[0] = c0;
        c[1] = c1;
        c[2] = c2;
        mx   = '0;
        sh   = '0;
        res  = '0;
        for (int i = 0; i < 3; i++) begin
            ng[i] = c[i][MW-1];
            m[i]  = ng[i] ? (~c[i] + 1'b1) : c[i];
            if (m[i] > mx) begin
                mx = m[i];
            end
        end
        mxe = EW'(mx);
        for (int s = 0; s < MW; s++) begin
            if ((mxe >> s) > EW'(NORM_LIMIT)) begin
                sh = sh + 1'b1;
            end
        end
        for (int i = 0; i < 3; i++) begin
            t  = m[i] >> sh;
            tz = NORM_W'(t);
            res[i*NORM_W +: NORM_W] = ng[i] ? (~tz + 1'b1) : tz;
        end
        return res;
    endfunction

    assign adv    = !r_v[NST-1] || !i_mid_full;
    assign o_full = !adv;
    assign o_push = r_v[NST-1] && !i_mid_full;
    assign o_mid  = r_out;

    assign w_na = norm_vec(r_in.ax, r_in.ay, r_in.az);
    assign w_nb = norm_vec(r_in.bx, r_in.by, r_in.bz);

    always_comb begin
        w_p[0] = r_a[0] * r_b[0];
        w_p[1] = r_a[1] * r_b[1];
        w_p[2] = r_a[2] * r_b[2];
        w_p[3] = r_a[1] * r_b[2];
        w_p[4] = r_a[2] * r_b[1];
        w_p[5] = r_a[2] * r_b[0];
        w_p[6] = r_a[0] * r_b[2];
        w_p[7] = r_a[0] * r_b[1];
        w_p[8] = r_a[1] * r_b[0];
    end

    always_comb begin
        w_dot   = r_p[0] + r_p[1] + r_p[2];
        w_cr[0] = r_p[3] - r_p[4];
        w_cr[1] = r_p[5] - r_p[6];
        w_cr[2] = r_p[7] - r_p[8];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[NST-2:0], i_push};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_in <= i_pair;
            for (int i = 0; i < 3; i++) begin
                r_a[i] <= signed'(w_na[i*NORM_W +: NORM_W]);
                r_b[i] <= signed'(w_nb[i*NORM_W +: NORM_W]);
            end
            r_dg1 <= (w_na == '0) || (w_nb == '0);
            for (int k = 0; k < 9; k++) begin
                r_p[k] <= signed'(w_p[k][31:0]);
            end
            r_dg2 <= r_dg1;
            for (int i = 0; i < 3; i++) begin
                r_cm[i] <= w_cr[i][32] ? 32'(-w_cr[i]) : w_cr[i][31:0];
            end
            r_dm  <= w_dot[32] ? 32'(-w_dot) : w_dot[31:0];
            r_dg3 <= r_dg2;
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= r_cm[i] * r_cm[i];
            end
            r_dm4 <= r_dm;
            r_dg4 <= r_dg3;
            r_out.cross2     <= r_sq[0] + r_sq[1] + r_sq[2];
            r_out.dot_mag    <= r_dm4;
            r_out.degenerate <= r_dg4;
        end
    end

endmodule

>>> hw/rtl/vpia_back.sv
`timescale 1ns / 1ps
// Back pipeline: square root, leading-zero scaling, CORDIC vectoring and rounding.
module vpia_back import vpia_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_vpia_mid i_mid,
    input  logic      i_mid_empty,
    output logic      o_mid_pop,
    output logic      o_push,
    input  logic      i_out_full,
    output t_vpia_out o_res
);
    localparam int NST  = 1 + SQRT_STEPS + 2 + CORDIC_STEPS + 1;
    localparam int XW   = 36;
    localparam int ZW   = 34;
    localparam int RSH  = TABLE_FRAC - ANGLE_FRAC_BITS;
    localparam logic [31:0] ZMAX = 32'(RIGHT_ANGLE) << TABLE_FRAC;
    localparam logic [31:0] AMAX = 32'(RIGHT_ANGLE) << ANGLE_FRAC_BITS;
    localparam logic [31:0] HALF = 32'd1 << (RSH - 1);

    logic [NST-1:0]        r_v;
    logic [NST-1:0]        r_dg;
    logic                  adv;
    logic [63:0]           r_rem [SQRT_STEPS+1];
    logic [63:0]           r_res [SQRT_STEPS+1];
    logic [31:0]           r_c   [SQRT_STEPS+1];
    logic [31:0]           w_s0;
    logic [31:0]           w_c0;
    logic [31:0]           w_s1;
    logic [31:0]           w_c1;
    logic [31:0]           r_s1;
    logic [31:0]           r_c1;
    logic [31:0]           w_s2;
    logic [31:0]           w_c2;
    logic signed [XW-1:0]  r_x [CORDIC_STEPS+1];
    logic signed [XW-1:0]  r_y [CORDIC_STEPS+1];
    logic signed [ZW-1:0]  r_z [CORDIC_STEPS+1];
    logic [31:0]           w_zq;
    logic [31:0]           w_ang;
    t_vpia_out             r_out;

    assign adv       = !r_v[NST-1] || !i_out_full;
    assign o_mid_pop = adv && !i_mid_empty;
    assign o_push    = r_v[NST-1] && !i_out_full;
    assign o_res     = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[NST-2:0], !i_mid_empty};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dg     <= {r_dg[NST-2:0], i_mid.degenerate};
            r_rem[0] <= i_mid.cross2;
            r_res[0] <= '0;
            r_c[0]   <= i_mid.dot_mag;
        end
    end

    // One result bit of the integer square root per stage.
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        localparam logic [63:0] BITV = 64'd1 << (2 * (SQRT_STEPS - 1 - k));
        logic [63:0] trial;
        assign trial = r_res[k] + BITV;
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_c[k+1] <= r_c[k];
                if (r_rem[k] >= trial) begin
                    r_rem[k+1] <= r_rem[k] - trial;
                    r_res[k+1] <= (r_res[k] >> 1) + BITV;
                end else begin
                    r_rem[k+1] <= r_rem[k];
                    r_res[k+1] <= r_res[k] >> 1;
                end
            end
        end
    end

    // Scale sine and cosine together so the larger has its top bit set.
    always_comb begin
        w_s0 = r_res[SQRT_STEPS][31:0];
        w_c0 = r_c[SQRT_STEPS];
        if ((w_s0[31:16] | w_c0[31:16]) == '0) begin
            w_s0 = w_s0 << 16;
            w_c0 = w_c0 << 16;
        end
        w_s1 = w_s0;
        w_c1 = w_c0;
        if ((w_s1[31:24] | w_c1[31:24]) == '0) begin
            w_s1 = w_s1 << 8;
            w_c1 = w_c1 << 8;
        end
    end

    always_comb begin
        w_s2 = r_s1;
        w_c2 = r_c1;
        if ((w_s2[31:28] | w_c2[31:28]) == '0) begin
            w_s2 = w_s2 << 4;
            w_c2 = w_c2 << 4;
        end
        if ((w_s2[31:30] | w_c2[31:30]) == '0) begin
            w_s2 = w_s2 << 2;
            w_c2 = w_c2 << 2;
        end
        if (!w_s2[31] && !w_c2[31]) begin
            w_s2 = w_s2 << 1;
            w_c2 = w_c2 << 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1   <= w_s1;
            r_c1   <= w_c1;
            r_x[0] <= signed'(XW'(w_c2));
            r_y[0] <= signed'(XW'(w_s2));
            r_z[0] <= '0;
        end
    end

    // Vectoring: drive y to zero, accumulate the rotation in z.
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        localparam logic signed [ZW-1:0] ATAN = signed'(ZW'(atan_q24(i)));
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;
        always_comb begin
            xs = r_x[i][XW-1] ? -((-r_x[i]) >>> i) : (r_x[i] >>> i);
            ys = r_y[i][XW-1] ? -((-r_y[i]) >>> i) : (r_y[i] >>> i);
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                if (r_y[i] != '0 && !r_y[i][XW-1]) begin
                    r_x[i+1] <= r_x[i] + ys;
                    r_y[i+1] <= r_y[i] - xs;
                    r_z[i+1] <= r_z[i] + ATAN;
                end else if (r_y[i][XW-1]) begin
                    r_x[i+1] <= r_x[i] - ys;
                    r_y[i+1] <= r_y[i] + xs;
                    r_z[i+1] <= r_z[i] - ATAN;
                end else begin
                    r_x[i+1] <= r_x[i];
                    r_y[i+1] <= r_y[i];
                    r_z[i+1] <= r_z[i];
                end
            end
        end
    end

    always_comb begin
        if (r_z[CORDIC_STEPS][ZW-1]) begin
            w_zq = '0;
        end else if (r_z[CORDIC_STEPS][ZW-2:0] > (ZW-1)'(ZMAX)) begin
            w_zq = ZMAX;
        end else begin
            w_zq = r_z[CORDIC_STEPS][31:0];
        end
        w_ang = (w_zq + HALF) >> RSH;
        if (w_ang > AMAX) begin
            w_ang = AMAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.angle_deg  <= r_dg[NST-2] ? '0 : w_ang[ANGLE_W-1:0];
            r_out.degenerate <= r_dg[NST-2];
        end
    end

endmodule
